### rtl/fpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpps_pkg: shared constants
// Horner coefficients (Q.30), Horner step count and tiny-mass limit.
// ----------------------------------------------------------------------------
package fpps_pkg;

  localparam int HORNER_STEPS = 6;

  localparam logic signed [31:0] C0 = 32'sd1158406367;

  // coefficients added after each Horner step, in order
  function automatic logic signed [31:0] horner_coef(input logic [2:0] idx);
    logic signed [31:0] c;
    case (idx)
      3'd0:    c = 32'sd146619446;
      3'd1:    c = -32'sd319373768;
      3'd2:    c = -32'sd223767796;
      3'd3:    c = 32'sd148723980;
      3'd4:    c = -32'sd20755429;
      3'd5:    c = 32'sd547608;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  localparam logic [63:0] TINY_Q64 = 64'd1844674408;

endpackage

### rtl/fpps_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpps_stream_if: valid/ready channel
// Generic payload channel with source and sink modports.
// ----------------------------------------------------------------------------
interface fpps_stream_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/four_pion_phase_space_factor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_pion_phase_space_factor_unit: four-pion phase space factor
// Squares a Q4.28 mass, evaluates polynomial or sqrt branch, gives momentum.
// ----------------------------------------------------------------------------
// One mass per clock is accepted on mass, and one result per clock leaves on
// result, whose data packs {phase_factor[31:0], breakup_momentum[31:0],
// used_polynomial}. Each item travels through a fixed pipeline of LAT register
// stages (square, divide, Horner, square root, momentum). Depth is set by the
// 32-step divider and the 32-step square root, one stage per result bit:
// LAT = 1 + 32 + 1 + 6 + 1 + 32 + 1 = 74. The whole pipe advances together:
// while the last stage holds a result that is not taken, every stage holds
// and mass.ready is low; otherwise a new mass can enter in every cycle. The
// threshold register is only to be written while no item is in flight.
module four_pion_phase_space_factor_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic          clk,
  input  logic          rst,
  fpps_stream_if.sink   cfg,
  fpps_stream_if.sink   mass,
  fpps_stream_if.source result
);

  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int DSTG  = 32;  // divider quotient bits after 32
  localparam int RSTG  = 32;  // square root result bits
  localparam int HS    = 1 + DSTG;                      // ctl index feeding Horner
  localparam int RS    = HS + fpps_pkg::HORNER_STEPS;   // ctl index of Horner result
  localparam int FS    = RS + 1 + RSTG;                 // ctl index of final stage
  localparam int LAT   = FS + 2;

  logic [31:0] threshold;
  logic        adv;
  logic [LAT-1:0] vld;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 32'd1338612457;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  // pipe advances when output slot is free or being taken
  assign adv          = !vld[LAT-1] || result.ready;
  assign mass.ready   = adv;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], mass.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: square and branch decisions
  // --------------------------------------------------------------------------
  logic signed [31:0] m_in;
  logic [31:0] am_in;
  logic [63:0] sq_in;
  logic [127:0] sq_w;
  logic        tiny_in, poly_in;
  logic [63:0] tiny_lim;
  logic [31:0] s30_in;
  logic [63:0] s32_in;

  assign m_in  = mass.data;
  assign am_in = m_in[31] ? 32'(-m_in) : m_in;
  assign sq_in = 64'(am_in) * 64'(am_in);
  assign sq_w  = {64'd0, sq_in};

  always_comb begin
    if (TWO_F >= 64) begin
      tiny_lim = 64'(fpps_pkg::TINY_Q64 << (TWO_F - 64));
    end else begin
      tiny_lim = (fpps_pkg::TINY_Q64 + (64'd1 << (64 - TWO_F)) - 64'd1) >> (64 - TWO_F);
    end
    tiny_in = sq_in < tiny_lim;
    poly_in = (TWO_F >= 63) || ({64'd0, sq_in} <= (128'd1 << TWO_F));
    // only the polynomial branch reads s30, and there it is at most 2^30
    s30_in  = 32'(sq_w >> (TWO_F - 30));
    s32_in  = 64'(sq_w >> (TWO_F - 32));
  end

  // shared per-stage payload
  typedef struct packed {
    logic signed [31:0] m;
    logic               tiny;
    logic               poly;
    logic [31:0]        s30;
  } ctl_t;

  ctl_t ctl [FS+1];

  // divider working registers
  logic [63:0] dv_s  [DSTG+1];
  logic [64:0] dv_rem[DSTG+1];
  logic [32:0] dv_q  [DSTG+1];
  // Horner accumulators in Q.30; |acc| < 2.0 on the polynomial branch
  logic signed [31:0] hacc [7];
  logic [31:0] arg_r [7];
  // square-root registers
  logic [63:0] sr_x [RSTG+1];
  logic [63:0] sr_r [RSTG+1];
  logic [31:0] fac_poly [RSTG+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= '{m: m_in, tiny: tiny_in, poly: poly_in, s30: s30_in};
      dv_s[0]   <= (s32_in == 64'd0) ? 64'd1 : s32_in;
      dv_rem[0] <= {33'd0, threshold};
      dv_q[0]   <= '0;
      for (int i = 1; i <= FS; i++) ctl[i] <= ctl[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Divider: (threshold << 32) / s32, one quotient bit per stage, saturated
  // --------------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < DSTG; g++) begin : g_div
      logic [64:0] r2;
      assign r2 = {dv_rem[g][63:0], 1'b0};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_s[g+1] <= dv_s[g];
          if (r2 >= {1'b0, dv_s[g]}) begin
            dv_rem[g+1] <= r2 - {1'b0, dv_s[g]};
            dv_q[g+1]   <= {dv_q[g][31:0], 1'b1};
          end else begin
            dv_rem[g+1] <= r2;
            dv_q[g+1]   <= {dv_q[g][31:0], 1'b0};
          end
        end
      end
    end
  endgenerate
  // high quotient part: threshold/s before shift, nonzero means saturate
  logic sat_hi [DSTG+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      sat_hi[0] <= ({32'd0, threshold} >= ((s32_in == 64'd0) ? 64'd1 : s32_in));
      for (int i = 1; i <= DSTG; i++) sat_hi[i] <= sat_hi[i-1];
    end
  end
  // note: quotient >= 2^32 iff threshold >= s, in which case the
  // initial remainder is at least s and the bit loop is invalid; saturate.

  // stage after divider: argument, start Horner
  always_ff @(posedge clk) begin
    if (adv) begin
      arg_r[0] <= sat_hi[DSTG] ? 32'd1 : 32'(~dv_q[DSTG][31:0] + 32'd1);
      hacc[0]  <= fpps_pkg::C0;
    end
  end

  generate
    for (g = 0; g < fpps_pkg::HORNER_STEPS; g++) begin : g_horner
      logic signed [63:0] p;
      logic signed [31:0] sh;
      assign p  = 64'(hacc[g]) * 64'($signed(ctl[HS+g].s30)) + (64'sd1 <<< 29);
      assign sh = 32'(p >>> 30);
      always_ff @(posedge clk) begin
        if (adv) begin
          hacc[g+1]  <= sh + fpps_pkg::horner_coef(3'(g));
          arg_r[g+1] <= arg_r[g];
        end
      end
    end
  endgenerate

  // clamp and start square root of arg << 30
  logic [31:0] fac_p_in;
  always_comb begin
    if (hacc[6] < 0) fac_p_in = '0;
    else if (hacc[6] > 32'sd1073741824) fac_p_in = 32'h8000_0000;
    else fac_p_in = {hacc[6][30:0], 1'b0};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sr_x[0] <= {arg_r[6] == 32'd0 ? 2'd1 : 2'd0, arg_r[6], 30'd0};
      sr_r[0] <= '0;
      fac_poly[0] <= fac_p_in;
    end
  end

  // bit-by-bit isqrt, bit = 4^(31-g)
  generate
    for (g = 0; g < RSTG; g++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (2 * (RSTG - 1 - g));
      always_ff @(posedge clk) begin
        if (adv) begin
          fac_poly[g+1] <= fac_poly[g];
          if (sr_x[g] >= sr_r[g] + BIT) begin
            sr_x[g+1] <= sr_x[g] - (sr_r[g] + BIT);
            sr_r[g+1] <= (sr_r[g] >> 1) + BIT;
          end else begin
            sr_x[g+1] <= sr_x[g];
            sr_r[g+1] <= sr_r[g] >> 1;
          end
        end
      end
    end
  endgenerate

  // final: select factor, momentum
  logic [32:0] fac_f;
  logic signed [65:0] mp;
  logic [31:0] pf_q, mo_q;
  logic        up_q;
  always_comb begin
    fac_f = ctl[FS].poly ? {1'b0, fac_poly[RSTG]} : 33'(sr_r[RSTG]);
    mp    = $signed({1'b0, fac_f}) * 66'(ctl[FS].m) + (66'sd1 <<< 31);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl[FS].tiny) begin
        pf_q <= '0;
        mo_q <= '0;
        up_q <= 1'b0;
      end else begin
        pf_q <= fac_f[31:0];
        mo_q <= 32'(mp >>> 32);
        up_q <= ctl[FS].poly;
      end
    end
  end
  assign result.data = {pf_q, mo_q, up_q};

  // ---------------------------- assertions ----------------------------------
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.data))
    else $error("output changed under stall");
  a_flag_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && up_q |-> pf_q <= 32'h8000_0000)
    else $error("polynomial factor above one");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> mass.ready)
    else $error("pipe blocked with empty output");

endmodule

### verif/four_pion_phase_space_factor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_pion_phase_space_factor_unit_tb: self-checking bench for the unit
// Drives masses through the stream port, predicts factor, momentum and branch
// flag in fixed point, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module four_pion_phase_space_factor_unit_tb;

  localparam int FRAC = 28;
  localparam int LAT = 74;
  localparam int WDOG_LIMIT = 4000;
  localparam logic [31:0] THR_RESET = 32'd1338612457;

  typedef struct packed {
    logic [31:0] factor;
    logic [31:0] momentum;
    logic        poly;
  } phase_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic out_valid;
  logic out_ready;
  logic [31:0] phase_factor;
  logic [31:0] breakup_momentum;
  logic used_polynomial;

  fpps_stream_if #(.WIDTH(32)) cfg ();
  fpps_stream_if #(.WIDTH(32)) in_ch ();
  fpps_stream_if #(.WIDTH(65)) out_ch ();

  four_pion_phase_space_factor_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst, .cfg(cfg.sink), .mass(in_ch.sink), .result(out_ch.source)
  );

  assign out_ch.ready     = out_ready;
  assign out_valid        = out_ch.valid;
  assign phase_factor     = out_ch.data[64:33];
  assign breakup_momentum = out_ch.data[32:1];
  assign used_polynomial  = out_ch.data[0];

  initial begin
    forever #1 clk = ~clk;
  end

  // bench-side copy of the threshold register
  logic [31:0] thr_model;
  phase_result_t pending_q[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int n_poly = 0, n_sqrt = 0, n_tiny = 0;
  int idle_cycles = 0;
  // stall controls: receiver stall bursts, a forced long receiver hold, and sender gaps
  bit sink_stall_en = 1'b0;
  bit sink_hold = 1'b0;
  bit src_stall_en = 1'b0;

  function automatic longint floor_shr(longint v, int sh);
    return v >>> sh;   // arithmetic shift is floor for signed values
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected factor, momentum and branch flag for one mass.
  function automatic phase_result_t phase_space_of(logic [31:0] mass);
    phase_result_t res;
    longint m, acc, s30, mom;
    longint unsigned am, sq, s32, q, arg, fac, tiny_lim;
    longint cf[6];
    cf = '{146619446, -319373768, -223767796, 148723980, -20755429, 547608};
    m = longint'($signed(mass));
    am = (m < 0) ? longint'(-m) : longint'(m);
    sq = am * am;
    tiny_lim = (64'd1844674408 + (64'd1 << (64 - 2 * FRAC)) - 1) >> (64 - 2 * FRAC);
    res = '0;
    if (sq < tiny_lim) return res;
    if (sq <= (64'd1 << (2 * FRAC))) begin
      res.poly = 1'b1;
      s30 = longint'(sq >> (2 * FRAC - 30));
      acc = 1158406367;
      for (int k = 0; k < 6; k++) acc = floor_shr(acc * s30 + (64'sd1 << 29), 30) + cf[k];
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      fac = longint'(acc) << 1;
    end else begin
      s32 = sq >> (2 * FRAC - 32);
      if (s32 == 0) s32 = 1;
      q = ({32'd0, thr_model} << 32) / s32;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      arg = (64'd1 << 32) - q;
      fac = int_sqrt(arg << 30);
    end
    mom = floor_shr(longint'(fac) * m + (64'sd1 << 31), 32);
    res.factor = fac[31:0];
    res.momentum = mom[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- driving
  // valid stays high after the transfer; a following send or drain_all
  // decides what the next cycle carries
  task automatic send_mass(logic [31:0] mass);
    if (src_stall_en && ($urandom_range(0, 5) == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= mass;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer took place at this edge
    pending_q.push_back(phase_space_of(mass));
    sent++;
  endtask

  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // only issued with nothing in flight
  task automatic write_threshold(logic [31:0] thr);
    drain_all();
    cfg.valid <= 1'b1;
    cfg.data <= thr;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    thr_model = thr;
  endtask

  // masses biased across the branches: tiny, polynomial, sqrt, full range
  function automatic logic [31:0] rand_mass();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 4);
      1: v = $urandom_range(0, 32'h1000_0000);
      2: v = $urandom_range(32'h1000_0000, 32'h4000_0000);
      3: v = $urandom_range(32'h0000_8000, 32'h000F_0000);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd1717, 32'd1718, 32'd1719,
             -32'd1718, 32'h1000_0000, 32'h1000_0001, 32'h0FFF_FFFF,
             32'hF000_0000, 32'hEFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h8000_0001, 32'h0800_0000, 32'h1200_0000, 32'h5555_5555,
             32'hAAAA_AAAA, 32'h0B50_0000};
    foreach (vals[k]) send_mass(vals[k]);
  endtask

  task automatic test_random(int n);
    repeat (n) send_mass(rand_mass());
  endtask

  // sink holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        int held;
        held = 0;
        while (held < 3 * LAT) begin
          @(posedge clk);
          held++;
        end
        sink_hold = 1'b0;
      end
    join_none
    repeat (150) send_mass(rand_mass());
  endtask

  task automatic test_thresholds();
    logic [31:0] thr_set[$];
    thr_set = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1};
    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      test_random(60);
    end
    write_threshold($urandom);
    test_random(60);
    write_threshold(THR_RESET);
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer: %h %h %b",
                                     phase_factor, breakup_momentum, used_polynomial);
        end else begin
          phase_result_t e;
          e = pending_q.pop_front();
          checked++;
          if (e.poly) n_poly++;
          else if (e.factor == 0 && e.momentum == 0) n_tiny++;
          else n_sqrt++;
          if (e.factor !== phase_factor || e.momentum !== breakup_momentum
              || e.poly !== used_polynomial) begin
            errors++;
            if (errors <= 10)
              $display("mismatch #%0d: exp f=%h p=%h u=%b, got f=%h p=%h u=%b",
                       checked, e.factor, e.momentum, e.poly,
                       phase_factor, breakup_momentum, used_polynomial);
          end
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    int burst;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
      end else if (sink_stall_en && burst == 0 && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= (burst == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_valid && out_ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    thr_model = THR_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    sink_stall_en = 1'b1;
    src_stall_en = 1'b1;
    test_thresholds();
    test_backpressure();
    // sender pauses until everything has come back
    drain_all();
    test_random(800);
    sink_stall_en = 1'b0;
    src_stall_en = 1'b0;
    test_random(200);
    drain_all();

    $display("checked %0d results from %0d masses: %0d polynomial, %0d sqrt, %0d tiny",
             checked, sent, n_poly, n_sqrt, n_tiny);
    $display("six threshold settings used, including zero and full scale");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
